@@ design/sil_pkg.sv @@
// Shared types, codes, constants and saturating helpers of the survey-index likelihood core.
package sil_pkg;

    localparam int AGE_ROWS    = 64;
    localparam int LENGTH_COLS = 256;

    localparam int ACC_W   = 48;
    localparam int DVD_W   = 72;
    localparam int ITER_W  = 7;
    localparam int LOG_STEPS = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [2:0] MODE_PEARSON = 3'd0;
    localparam logic [2:0] MODE_MULTI   = 3'd1;
    localparam logic [2:0] MODE_EXPER   = 3'd2;
    localparam logic [2:0] MODE_GAMMA   = 3'd3;
    localparam logic [2:0] MODE_LOGR    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EPS  = 2'd1;

    localparam logic [31:0] EPS_RESET = 32'd655;

    localparam logic [ITER_W-1:0] DIV_ITERS_FRAC = 7'd56;
    localparam logic [ITER_W-1:0] DIV_ITERS_WIDE = 7'd72;

    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    typedef logic signed [ACC_W-1:0] acc_t;

    localparam acc_t SAT_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam acc_t SAT_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [ACC_W-1:0]  divisor;
        logic [ITER_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] x;
        logic             frac24;
    } log_req_t;

    function automatic acc_t sat_add(acc_t a, acc_t b);
        logic [ACC_W:0] s;
        acc_t           r;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            r = s[ACC_W] ? SAT_MIN : SAT_MAX;
        end else begin
            r = $signed(s[ACC_W-1:0]);
        end
        return r;
    endfunction

    function automatic logic [ACC_W-1:0] mag48(acc_t v);
        logic [ACC_W-1:0] r;
        r = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        return r;
    endfunction

endpackage

@@ design/sil_div.sv @@
// Bit-serial restoring divider: saturated floor of dividend over divisor, one quotient bit a cycle.
module sil_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  sil_pkg::div_req_t req,
    output logic              busy,
    output logic [47:0]       quot
);

    logic                busy_reg;
    logic [6:0]          cnt_reg;
    logic [71:0]         dvd_reg;
    logic [47:0]         den_reg;
    logic [47:0]         rem_reg;
    logic [47:0]         q_reg;
    logic                ovf_reg;

    logic [48:0]         shift_next;
    logic [49:0]         diff_next;
    logic                take_next;
    logic [47:0]         rem_next;

    always_comb begin
        shift_next = {rem_reg, dvd_reg[71]};
        diff_next  = {1'b0, shift_next} - {2'b00, den_reg};
        take_next  = ~diff_next[49];
        rem_next   = take_next ? diff_next[47:0] : shift_next[47:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (req.start) begin
            ovf_reg <= 1'b0;
            if (req.divisor == '0) begin
                // zero divisor: saturate on a nonzero dividend
                busy_reg <= 1'b0;
                q_reg    <= (req.dividend != '0) ? 48'(sil_pkg::SAT_MAX) : 48'd0;
            end else begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.iters;
                dvd_reg  <= req.dividend;
                den_reg  <= req.divisor;
                rem_reg  <= '0;
                q_reg    <= '0;
            end
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[70:0], 1'b0};
            q_reg   <= {q_reg[46:0], take_next};
            ovf_reg <= ovf_reg | q_reg[47];
            cnt_reg <= cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign quot = (ovf_reg || q_reg[47]) ? 48'(sil_pkg::SAT_MAX) : q_reg;

endmodule

@@ design/sil_log.sv @@
// Iterative natural log, result in signed Q8.24: normalize, 24 squaring steps for log2, scale by ln2.
module sil_log (
    input  logic               aclk,
    input  logic               aresetn,
    input  sil_pkg::log_req_t  req,
    output logic               busy,
    output logic signed [31:0] result
);

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_NORM = 3'd1;
    localparam logic [2:0] L_SQR  = 3'd2;
    localparam logic [2:0] L_ABS  = 3'd3;
    localparam logic [2:0] L_MUL  = 3'd4;
    localparam logic [2:0] L_RND  = 3'd5;

    logic [2:0]         st_reg;
    logic [47:0]        x_reg;
    logic [5:0]         p_reg;
    logic               fb24_reg;
    logic [30:0]        m_reg;
    logic [23:0]        f_reg;
    logic [4:0]         step_reg;
    logic               neg_reg;
    logic [29:0]        mag_reg;
    logic [59:0]        prod_reg;
    logic signed [31:0] res_reg;

    logic [61:0]        sq_next;
    logic [31:0]        t_next;
    logic [6:0]         ip_next;
    logic [30:0]        l2_next;
    logic [30:0]        abs_next;
    logic [59:0]        rnd_next;
    logic [31:0]        rmag_next;

    always_comb begin
        sq_next   = 62'(m_reg) * 62'(m_reg);
        t_next    = sq_next[61:30];
        ip_next   = {1'b0, p_reg} - (fb24_reg ? 7'd24 : 7'd16);
        l2_next   = {ip_next, f_reg};
        abs_next  = l2_next[30] ? 31'(-l2_next) : l2_next;
        rnd_next  = prod_reg + 60'(1 << 29);
        rmag_next = {2'b00, rnd_next[59:30]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= L_IDLE;
        end else begin
            unique case (st_reg)
                L_IDLE: begin
                    if (req.start) begin
                        // log of zero reads as log of one lsb
                        x_reg    <= (req.x == '0) ? 48'd1 : req.x;
                        p_reg    <= 6'd47;
                        fb24_reg <= req.frac24;
                        st_reg   <= L_NORM;
                    end
                end
                L_NORM: begin
                    if (x_reg[47:40] == 8'd0) begin
                        x_reg <= {x_reg[39:0], 8'd0};
                        p_reg <= p_reg - 6'd8;
                    end else if (!x_reg[47]) begin
                        x_reg <= {x_reg[46:0], 1'b0};
                        p_reg <= p_reg - 6'd1;
                    end else begin
                        m_reg    <= x_reg[47:17];
                        f_reg    <= '0;
                        step_reg <= '0;
                        st_reg   <= L_SQR;
                    end
                end
                L_SQR: begin
                    m_reg    <= t_next[31] ? t_next[31:1] : t_next[30:0];
                    f_reg    <= {f_reg[22:0], t_next[31]};
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(sil_pkg::LOG_STEPS - 1)) begin
                        st_reg <= L_ABS;
                    end
                end
                L_ABS: begin
                    neg_reg <= l2_next[30];
                    mag_reg <= abs_next[29:0];
                    st_reg  <= L_MUL;
                end
                L_MUL: begin
                    prod_reg <= 60'(mag_reg) * 60'(sil_pkg::LN2_Q30);
                    st_reg   <= L_RND;
                end
                L_RND: begin
                    res_reg <= neg_reg ? -$signed(rmag_next) : $signed(rmag_next);
                    st_reg  <= L_IDLE;
                end
                default: st_reg <= L_IDLE;
            endcase
        end
    end

    assign busy   = (st_reg != L_IDLE);
    assign result = res_reg;

endmodule

@@ design/survey_index_likelihood_core.sv @@
// Top level of the survey-index likelihood core: cell sequencer, step accumulators, result beat.
//
// The core takes the cells of one time step as input beats and folds each into one of five
// goodness-of-fit sums (Pearson, multinomial, experimental, gamma, log ratio of sums), picked
// by the likelihood_mode register. On the beat with s_tlast high it sends one result beat
// with the step likelihood, the largest tracked contribution and its cell, then clears the
// step state. Cells go through one at a time; the cost is set by two shared serial units:
// a restoring divider that makes one quotient bit a cycle and a log unit that normalizes,
// squares and scales. The result sits in an output register, so the next cell is taken
// while the result beat waits. Write the registers only while the core is idle.
module survey_index_likelihood_core (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    // observed[31:0], modelled[63:32], age_row[69:64], length_col[77:70], zero pad[79:78]
    input  logic [79:0]  s_tdata,
    input  logic         s_tlast,

    output logic         m_tvalid,
    input  logic         m_tready,
    // step_likelihood[47:0], max_contribution[95:48], max_age[101:96],
    // max_length[109:102], zero pad[111:110]
    output logic [111:0] m_tdata,
    // status[0]
    output logic [0:0]   m_tuser,

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CELL   = 4'd1;
    localparam logic [3:0] S_PDIV   = 4'd2;
    localparam logic [3:0] S_WAIT   = 4'd3;
    localparam logic [3:0] S_POST   = 4'd4;
    localparam logic [3:0] S_MACC   = 4'd5;
    localparam logic [3:0] S_END    = 4'd6;
    localparam logic [3:0] S_FWAIT  = 4'd7;
    localparam logic [3:0] S_FPOST  = 4'd8;
    localparam logic [3:0] S_FWAIT2 = 4'd9;
    localparam logic [3:0] S_FDIFF  = 4'd10;
    localparam logic [3:0] S_FMUL   = 4'd11;
    localparam logic [3:0] S_FRES   = 4'd12;
    localparam logic [3:0] S_EMIT   = 4'd13;

    // configuration
    logic [2:0]  mode_cfg_reg;
    logic [31:0] eps_reg;

    // sequencer and latched cell
    logic [3:0]  state_reg;
    logic [31:0] o_reg;
    logic [31:0] m_reg;
    logic [5:0]  age_reg;
    logic [7:0]  len_reg;
    logic        last_reg;
    logic [2:0]  mode_reg;
    logic        inr_reg;

    // step state
    sil_pkg::acc_t term_sum_reg;
    sil_pkg::acc_t obs_sum_reg;
    sil_pkg::acc_t mod_sum_reg;
    sil_pkg::acc_t best_val_reg;
    logic [5:0]    best_age_reg;
    logic [7:0]    best_len_reg;

    // datapath scratch
    logic [63:0]        mul_reg;
    sil_pkg::acc_t      tmp_reg;
    logic signed [31:0] l1_reg;
    logic [29:0]        absd_reg;
    sil_pkg::acc_t      res_reg;
    logic               status_reg;

    // result register
    logic          m_valid_reg;
    sil_pkg::acc_t out_like_reg;
    sil_pkg::acc_t out_max_reg;
    logic [5:0]    out_age_reg;
    logic [7:0]    out_len_reg;
    logic          out_status_reg;

    sil_pkg::div_req_t  div_req;
    sil_pkg::log_req_t  log_req;
    logic               div_busy;
    logic               log_busy;
    logic [47:0]        quot;
    logic signed [31:0] log_res;

    logic               in_fire;
    logic               out_free;
    logic [31:0]        d_val;
    logic [32:0]        mpe;
    logic [33:0]        den3;
    logic               sums_ok;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [31:0]        log_abs;
    sil_pkg::acc_t      log_ext;
    sil_pkg::acc_t      q_signed;
    sil_pkg::acc_t      v_pos;
    sil_pkg::acc_t      v_val;
    sil_pkg::acc_t      f_val;
    sil_pkg::acc_t      mq_val;
    logic signed [31:0] ldiff;
    logic               tracked;

    sil_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .busy    (div_busy),
        .quot    (quot)
    );

    sil_log u_log (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (log_req),
        .busy    (log_busy),
        .result  (log_res)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    // register writes; indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_cfg_reg <= sil_pkg::MODE_PEARSON;
            eps_reg      <= sil_pkg::EPS_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sil_pkg::REG_MODE: mode_cfg_reg <= cfg_data[2:0];
                sil_pkg::REG_EPS:  eps_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // cell arithmetic shared by several modes
    always_comb begin
        d_val    = (m_reg >= o_reg) ? (m_reg - o_reg) : (o_reg - m_reg);
        mpe      = {1'b0, m_reg} + {1'b0, eps_reg};
        den3     = {2'b00, m_reg} + {2'b00, o_reg} + {2'b00, eps_reg};
        sums_ok  = !obs_sum_reg[47] && (obs_sum_reg != '0) &&
                   !mod_sum_reg[47] && (mod_sum_reg != '0);
        log_abs  = log_res[31] ? 32'(-log_res) : 32'(log_res);
        log_ext  = {{16{log_res[31]}}, log_res};
        q_signed = term_sum_reg[47] ? -$signed(quot) : $signed(quot);
        v_pos    = $signed({3'b000, mul_reg[60:16]});
        v_val    = log_res[31] ? -v_pos : v_pos;
        f_val    = (o_reg > m_reg) ? -$signed(quot) : $signed(quot);
        mq_val   = $signed({8'd0, m_reg, 8'd0});
        ldiff    = l1_reg - log_res;
        tracked  = (mode_reg == sil_pkg::MODE_MULTI) || (mode_reg == sil_pkg::MODE_EXPER) ||
                   (mode_reg == sil_pkg::MODE_LOGR);
    end

    // one shared multiplier; its product is always registered
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_CELL: begin
                mul_a = d_val;
                mul_b = d_val;
            end
            S_POST: begin
                if (mode_reg == sil_pkg::MODE_MULTI) begin
                    mul_a = o_reg;
                    mul_b = log_abs;
                end else begin
                    mul_a = quot[31:0];
                    mul_b = quot[31:0];
                end
            end
            S_FMUL: begin
                mul_a = {2'b00, absd_reg};
                mul_b = {2'b00, absd_reg};
            end
            default: ;
        endcase
    end

    // start requests for the divider and the log unit
    always_comb begin
        div_req = '0;
        log_req = '0;
        unique case (state_reg)
            S_CELL: begin
                if (inr_reg) begin
                    unique case (mode_reg)
                        sil_pkg::MODE_MULTI: begin
                            log_req.start = (o_reg > eps_reg);
                            log_req.x     = {15'd0, mpe};
                        end
                        sil_pkg::MODE_EXPER: begin
                            div_req.start    = 1'b1;
                            div_req.dividend = {d_val, 40'd0};
                            div_req.divisor  = {14'd0, den3};
                            div_req.iters    = sil_pkg::DIV_ITERS_FRAC;
                        end
                        sil_pkg::MODE_GAMMA: begin
                            div_req.start    = 1'b1;
                            div_req.dividend = {o_reg, 40'd0};
                            div_req.divisor  = {15'd0, mpe};
                            div_req.iters    = sil_pkg::DIV_ITERS_FRAC;
                            log_req.start    = 1'b1;
                            log_req.x        = {15'd0, mpe};
                        end
                        default: ;
                    endcase
                end
            end
            S_PDIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = {mul_reg, 8'd0};
                div_req.divisor  = {15'd0, mpe};
                div_req.iters    = sil_pkg::DIV_ITERS_WIDE;
            end
            S_END: begin
                if (last_reg && sums_ok) begin
                    if (mode_reg == sil_pkg::MODE_MULTI) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {sil_pkg::mag48(term_sum_reg), 24'd0};
                        div_req.divisor  = obs_sum_reg;
                        div_req.iters    = sil_pkg::DIV_ITERS_WIDE;
                        log_req.start    = 1'b1;
                        log_req.x        = mod_sum_reg;
                        log_req.frac24   = 1'b1;
                    end else if (mode_reg == sil_pkg::MODE_LOGR) begin
                        log_req.start    = 1'b1;
                        log_req.x        = obs_sum_reg;
                        log_req.frac24   = 1'b1;
                    end
                end
            end
            S_FPOST: begin
                if (mode_reg == sil_pkg::MODE_LOGR) begin
                    log_req.start  = 1'b1;
                    log_req.x      = mod_sum_reg;
                    log_req.frac24 = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // sequencer and step accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            term_sum_reg <= '0;
            obs_sum_reg  <= '0;
            mod_sum_reg  <= '0;
            best_val_reg <= '0;
            best_age_reg <= '0;
            best_len_reg <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        o_reg     <= s_tdata[31:0];
                        m_reg     <= s_tdata[63:32];
                        age_reg   <= s_tdata[69:64];
                        len_reg   <= s_tdata[77:70];
                        last_reg  <= s_tlast;
                        mode_reg  <= mode_cfg_reg;
                        inr_reg   <= (int'(s_tdata[69:64]) < sil_pkg::AGE_ROWS) &&
                                     (int'(s_tdata[77:70]) < sil_pkg::LENGTH_COLS);
                        state_reg <= S_CELL;
                    end
                end
                S_CELL: begin
                    mul_reg <= 64'(mul_a) * 64'(mul_b);
                    if (!inr_reg) begin
                        // out-of-range cell: add nothing, still honor the last mark
                        state_reg <= S_END;
                    end else begin
                        unique case (mode_reg)
                            sil_pkg::MODE_PEARSON: state_reg <= S_PDIV;
                            sil_pkg::MODE_MULTI:
                                state_reg <= (o_reg > eps_reg) ? S_WAIT : S_END;
                            sil_pkg::MODE_EXPER:   state_reg <= S_WAIT;
                            sil_pkg::MODE_GAMMA:   state_reg <= S_WAIT;
                            sil_pkg::MODE_LOGR: begin
                                obs_sum_reg <= sil_pkg::sat_add(obs_sum_reg,
                                                                $signed({8'd0, o_reg, 8'd0}));
                                mod_sum_reg <= sil_pkg::sat_add(mod_sum_reg, mq_val);
                                if (best_val_reg < mq_val) begin
                                    best_val_reg <= mq_val;
                                    best_age_reg <= age_reg;
                                    best_len_reg <= len_reg;
                                end
                                state_reg <= S_END;
                            end
                            default: state_reg <= S_END;
                        endcase
                    end
                end
                S_PDIV: state_reg <= S_WAIT;
                S_WAIT: begin
                    if (!div_busy && !log_busy) begin
                        state_reg <= S_POST;
                    end
                end
                S_POST: begin
                    mul_reg <= 64'(mul_a) * 64'(mul_b);
                    if (mode_reg == sil_pkg::MODE_PEARSON) begin
                        term_sum_reg <= sil_pkg::sat_add(term_sum_reg, $signed(quot));
                        state_reg    <= S_END;
                    end else begin
                        tmp_reg   <= sil_pkg::sat_add($signed(quot), log_ext);
                        state_reg <= S_MACC;
                    end
                end
                S_MACC: begin
                    if (mode_reg == sil_pkg::MODE_MULTI) begin
                        term_sum_reg <= sil_pkg::sat_add(term_sum_reg, -v_val);
                        obs_sum_reg  <= sil_pkg::sat_add(obs_sum_reg,
                                                         $signed({8'd0, o_reg, 8'd0}));
                        mod_sum_reg  <= sil_pkg::sat_add(mod_sum_reg,
                                                         $signed({7'd0, mpe, 8'd0}));
                        if (sil_pkg::mag48(v_val) > sil_pkg::mag48(best_val_reg)) begin
                            best_val_reg <= v_val;
                            best_age_reg <= age_reg;
                            best_len_reg <= len_reg;
                        end
                    end else if (mode_reg == sil_pkg::MODE_EXPER) begin
                        term_sum_reg <= sil_pkg::sat_add(term_sum_reg,
                                                         $signed({23'd0, mul_reg[48:24]}));
                        if (f_val > best_val_reg) begin
                            best_val_reg <= f_val;
                            best_age_reg <= age_reg;
                            best_len_reg <= len_reg;
                        end
                    end else begin
                        term_sum_reg <= sil_pkg::sat_add(term_sum_reg, tmp_reg);
                    end
                    state_reg <= S_END;
                end
                S_END: begin
                    status_reg <= 1'b0;
                    res_reg    <= '0;
                    if (!last_reg) begin
                        state_reg <= S_IDLE;
                    end else begin
                        unique case (mode_reg)
                            sil_pkg::MODE_PEARSON, sil_pkg::MODE_EXPER,
                            sil_pkg::MODE_GAMMA: begin
                                res_reg   <= term_sum_reg;
                                state_reg <= S_EMIT;
                            end
                            sil_pkg::MODE_MULTI, sil_pkg::MODE_LOGR: begin
                                // empty sum: force zero and flag it
                                status_reg <= !sums_ok;
                                state_reg  <= sums_ok ? S_FWAIT : S_EMIT;
                            end
                            default: begin
                                status_reg <= 1'b1;
                                state_reg  <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_FWAIT: begin
                    if (!div_busy && !log_busy) begin
                        state_reg <= S_FPOST;
                    end
                end
                S_FPOST: begin
                    if (mode_reg == sil_pkg::MODE_MULTI) begin
                        res_reg   <= sil_pkg::sat_add(q_signed, log_ext);
                        state_reg <= S_EMIT;
                    end else begin
                        l1_reg    <= log_res;
                        state_reg <= S_FWAIT2;
                    end
                end
                S_FWAIT2: begin
                    if (!log_busy) begin
                        state_reg <= S_FDIFF;
                    end
                end
                S_FDIFF: begin
                    absd_reg  <= ldiff[31] ? 30'(-ldiff) : ldiff[29:0];
                    state_reg <= S_FMUL;
                end
                S_FMUL: begin
                    mul_reg   <= 64'(mul_a) * 64'(mul_b);
                    state_reg <= S_FRES;
                end
                S_FRES: begin
                    res_reg   <= $signed({12'd0, mul_reg[59:24]});
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    // hold until the result register is free, then clear the step
                    if (out_free) begin
                        term_sum_reg <= '0;
                        obs_sum_reg  <= '0;
                        mod_sum_reg  <= '0;
                        best_val_reg <= '0;
                        best_age_reg <= '0;
                        best_len_reg <= '0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_EMIT && out_free) begin
            m_valid_reg    <= 1'b1;
            out_like_reg   <= res_reg;
            out_status_reg <= status_reg;
            out_max_reg    <= tracked ? best_val_reg : '0;
            out_age_reg    <= tracked ? best_age_reg : '0;
            out_len_reg    <= tracked ? best_len_reg : '0;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {2'b00, out_len_reg, out_age_reg, out_max_reg, out_like_reg};
    assign m_tuser[0] = out_status_reg;

    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[47:0] == 48'd0))
        else $error("flagged result beat carries a nonzero likelihood");

    a_units_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (!div_busy && !log_busy))
        else $error("serial unit still busy while taking a new cell");

    a_sums_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        !obs_sum_reg[47] && !mod_sum_reg[47])
        else $error("step sum went negative");

    a_step_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && out_free) |=>
            (term_sum_reg == '0 && obs_sum_reg == '0 && mod_sum_reg == '0 &&
             best_val_reg == '0))
        else $error("step state not cleared after result");

endmodule
